// ----- rtl/xnce_pkg.sv -----
// ============================================================================
// xnce_pkg: shared types, constants and character classes
// Payload structures, the token and job records passed from the window
// stage to the expander, and the XML name character classification functions.
// ============================================================================
package xnce_pkg;

   localparam int CODE_W    = 21;
   localparam int WIN_DEPTH = 6;
   localparam int JOB_DEPTH = 7;
   localparam int CNT_W     = 3;

   // Window occupancy at which the next character completes the look-ahead.
   localparam logic [CNT_W-1:0] WIN_FULL = 3'd6;
   // Position of the closing underscore inside an escape sequence.
   localparam logic [CNT_W-1:0] ESC_LAST = 3'd6;

   localparam logic [CODE_W-1:0] CH_UNDERSCORE = 21'h00005F;
   localparam logic [CODE_W-1:0] CH_X          = 21'h000078;
   localparam logic [CODE_W-1:0] CH_COLON      = 21'h00003A;
   localparam logic [CODE_W-1:0] CH_HYPHEN     = 21'h00002D;
   localparam logic [CODE_W-1:0] CH_PERIOD     = 21'h00002E;
   localparam logic [CODE_W-1:0] CH_MIDDOT     = 21'h0000B7;

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              name_end;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] out_code;
      logic              run_last;
      logic              name_done;
   } rsp_type;

   // One character to be written, either as is or as an escape sequence.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              esc;
   } token_type;

   // All tokens caused by one input beat.
   typedef struct packed {
      token_type [JOB_DEPTH-1:0] tok;
      logic [CNT_W-1:0]          count;
      logic                      name_end;
   } job_type;

   function automatic logic in_rng(input logic [CODE_W-1:0] c,
                                   input logic [CODE_W-1:0] lo,
                                   input logic [CODE_W-1:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic is_alnum(input logic [CODE_W-1:0] c);
      return in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A)
          || in_rng(c, 21'h30, 21'h39);
   endfunction

   function automatic logic start_plain(input logic [CODE_W-1:0] c);
      return in_rng(c, 21'h41, 21'h5A) || (c == CH_UNDERSCORE)
          || in_rng(c, 21'h61, 21'h7A)
          || in_rng(c, 21'h0C0, 21'h0D6) || in_rng(c, 21'h0D8, 21'h0F6)
          || in_rng(c, 21'h0F8, 21'h2FF) || in_rng(c, 21'h370, 21'h37D)
          || in_rng(c, 21'h37F, 21'h1FFF) || in_rng(c, 21'h200C, 21'h200D)
          || in_rng(c, 21'h2070, 21'h218F) || in_rng(c, 21'h2C00, 21'h2FEF)
          || in_rng(c, 21'h3001, 21'hD7FF) || in_rng(c, 21'hF900, 21'hFDCF)
          || in_rng(c, 21'hFDF0, 21'hFFFD) || in_rng(c, 21'h10000, 21'hEFFFF);
   endfunction

   function automatic logic start_char(input logic [CODE_W-1:0] c,
                                       input logic esc_colon);
      return ((c == CH_COLON) && !esc_colon) || start_plain(c);
   endfunction

   function automatic logic name_char(input logic [CODE_W-1:0] c,
                                      input logic esc_colon);
      return start_char(c, esc_colon) || (c == CH_HYPHEN) || (c == CH_PERIOD)
          || in_rng(c, 21'h30, 21'h39) || (c == CH_MIDDOT)
          || in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h203F, 21'h2040);
   endfunction

   // Upper-case ASCII hex digit for one nibble.
   function automatic logic [CODE_W-1:0] hex_ascii(input logic [3:0] n);
      logic [CODE_W-1:0] base;
      base = (n < 4'd10) ? 21'h30 : 21'h37;
      return base + {17'd0, n};
   endfunction

endpackage

// ----- rtl/xml_ncname_ucs2_escaper.sv -----
// ============================================================================
// xml_ncname_ucs2_escaper: XML name escaper with _xHHHH_ encoding
// Takes the code points of a name one beat at a time and writes the encoded
// name, escaping non-name characters and pattern-starting underscores.
// ============================================================================
// Usage:
// The req_ channel carries one code point per beat with name_end on the last
// character of a name. The rsp_ channel carries one output code point per beat;
// run_last marks the final result of an input beat and name_done the final
// result of the name. csr_wr_en writes escape_colon; write it only while idle.
// A character after the first of a name is held until six more characters of
// that name arrive or the name ends, so some input beats give no result.
// The job register holds the tokens of an accepted beat, and each result is
// written through the registered result port.
// Throughput: one input beat per cycle while each beat gives at most one
// result and the receiver does not stall; the expander writes one output
// character per cycle while not stalled and takes the next beat with the last
// result of a beat (an escape sequence gives seven, a name end up to 49).
// When the receiver stalls, the result register holds its beat and req_ready
// stays high only while the expander holds no job, so at most one more beat
// that causes results is taken before req_ready falls.
// Reset clears the window, marks the next character as the first of a name,
// empties the output and sets escape_colon to zero.
// ============================================================================
module xml_ncname_ucs2_escaper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xnce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xnce_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import xnce_pkg::*;

   logic    esc_colon_ff, esc_colon_in;
   logic    accept;
   logic    take;
   job_type job;

   // Configuration register.
   assign esc_colon_in = csr_wr_en ? csr_wr_data : esc_colon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_colon_ff <= 1'b0;
      end else begin
         esc_colon_ff <= esc_colon_in;
      end
   end

   // Input handshake.
   assign req_ready = take;
   assign accept    = req_valid && take;

   xnce_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_data),
      .esc_colon (esc_colon_ff),
      .job       (job)
   );

   xnce_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .job       (job),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/xnce_window.sv -----
// ============================================================================
// xnce_window: look-ahead window and character decisions
// Holds up to six later characters of the current name, decides on each
// accepted beat which characters leave the window and whether each one is
// escaped, and presents them as a job for the expander.
// ============================================================================
module xnce_window (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  xnce_pkg::req_type item,
   input  logic             esc_colon,
   output xnce_pkg::job_type job
);
   import xnce_pkg::*;

   logic [CODE_W-1:0] win_ff [WIN_DEPTH];
   logic [CODE_W-1:0] win_in [WIN_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              first_ff, first_in;

   logic [CODE_W-1:0] nw [WIN_DEPTH];
   logic [CODE_W-1:0] ch;
   logic [CNT_W-1:0]  count_n;
   logic [CNT_W-1:0]  flush_n;
   logic              full;
   logic              head_emit;
   logic              pattern;
   token_type         head_tok;

   // Window update and token list for the beat on the input.
   always_comb begin
      ch   = item.char_code;
      full = (count_ff == WIN_FULL);

      // New window contents: shift out the head when full, else append.
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
         if (full) begin
            nw[k] = win_ff[k+1];
         end else begin
            nw[k] = (count_ff == CNT_W'(k)) ? ch : win_ff[k];
         end
      end
      nw[WIN_DEPTH-1] = (full || (count_ff == CNT_W'(WIN_DEPTH - 1)))
                        ? ch : win_ff[WIN_DEPTH-1];
      count_n = full ? WIN_FULL : count_ff + 3'd1;

      // The head starts the underscore pattern if the arriving character closes it.
      pattern = (win_ff[0] == CH_UNDERSCORE) && (win_ff[1] == CH_X)
             && is_alnum(win_ff[2]) && is_alnum(win_ff[3])
             && is_alnum(win_ff[4]) && is_alnum(win_ff[5])
             && (ch == CH_UNDERSCORE);

      head_emit    = !first_ff && full;
      head_tok     = '{code: win_ff[0], esc: pattern || !name_char(win_ff[0], esc_colon)};
      flush_n      = item.name_end ? count_n : 3'd0;

      // Token list: optional head, then the flushed window.
      job.name_end = item.name_end;
      if (head_emit) begin
         job.tok[0] = head_tok;
         for (int j = 1; j < JOB_DEPTH; j++) begin
            job.tok[j] = '{code: nw[j-1], esc: !name_char(nw[j-1], esc_colon)};
         end
         job.count = flush_n + 3'd1;
      end else begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            job.tok[j] = '{code: nw[j], esc: !name_char(nw[j], esc_colon)};
         end
         job.tok[JOB_DEPTH-1] = job.tok[0];
         job.count            = flush_n;
      end

      // The first character of a name is decided at once and never buffered.
      if (first_ff) begin
         job.tok[0] = '{code: ch, esc: !start_char(ch, esc_colon)};
         job.count  = 3'd1;
      end

      // Next state.
      first_in = first_ff;
      count_in = count_ff;
      for (int k = 0; k < WIN_DEPTH; k++) begin
         win_in[k] = win_ff[k];
      end
      if (accept) begin
         first_in = item.name_end;
         if (first_ff) begin
            count_in = 3'd0;
         end else begin
            count_in = item.name_end ? 3'd0 : count_n;
            for (int k = 0; k < WIN_DEPTH; k++) begin
               win_in[k] = nw[k];
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

   // Held characters.
   always_ff @(posedge clock) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

endmodule

// ----- rtl/xnce_expand.sv -----
// ============================================================================
// xnce_expand: job register and escape expander
// Holds the tokens of one beat, writes each as itself or as the seven
// characters of its escape sequence, and drives the registered result port.
// ============================================================================
module xnce_expand (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  xnce_pkg::job_type job,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xnce_pkg::rsp_type rsp_data
);
   import xnce_pkg::*;

   token_type        tok_ff [JOB_DEPTH];
   token_type        tok_in [JOB_DEPTH];
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              busy;
   logic              out_load;
   logic              tok_done;
   logic              last_tok;
   logic [CODE_W-1:0] esc_char;
   logic [CODE_W-1:0] head_code;

   // Character selection for the head token.
   always_comb begin
      head_code = tok_ff[0].code;
      unique case (idx_ff)
         3'd0:    esc_char = CH_UNDERSCORE;
         3'd1:    esc_char = CH_X;
         3'd2:    esc_char = hex_ascii(head_code[15:12]);
         3'd3:    esc_char = hex_ascii(head_code[11:8]);
         3'd4:    esc_char = hex_ascii(head_code[7:4]);
         3'd5:    esc_char = hex_ascii(head_code[3:0]);
         default: esc_char = CH_UNDERSCORE;
      endcase
   end

   // Sequencing of tokens and characters, and the output register.
   always_comb begin
      busy     = (left_ff != 3'd0);
      out_load = busy && (!rsp_valid_ff || rsp_ready);
      tok_done = !tok_ff[0].esc || (idx_ff == ESC_LAST);
      last_tok = (left_ff == 3'd1);
      take     = !busy || (out_load && tok_done && last_tok);

      for (int j = 0; j < JOB_DEPTH; j++) begin
         tok_in[j] = tok_ff[j];
      end
      left_in = left_ff;
      idx_in  = idx_ff;
      end_in  = end_ff;

      if (out_load) begin
         if (tok_done) begin
            idx_in  = 3'd0;
            left_in = left_ff - 3'd1;
            for (int j = 0; j < JOB_DEPTH - 1; j++) begin
               tok_in[j] = tok_ff[j+1];
            end
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end

      // A new job replaces the one that has just finished.
      if (accept && (job.count != 3'd0)) begin
         for (int j = 0; j < JOB_DEPTH; j++) begin
            tok_in[j] = job.tok[j];
         end
         left_in = job.count;
         idx_in  = 3'd0;
         end_in  = job.name_end;
      end

      rsp_data_in.out_code  = tok_ff[0].esc ? esc_char : head_code;
      rsp_data_in.run_last  = tok_done && last_tok;
      rsp_data_in.name_done = tok_done && last_tok && end_ff;

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int j = 0; j < JOB_DEPTH; j++) begin
         tok_ff[j] <= tok_in[j];
      end
      end_ff <= end_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- test/xml_ncname_ucs2_escaper_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// xml_ncname_ucs2_escaper_test: self-checking bench for the XML name escaper
// Streams names of code points into the escaper. Beats go in and out under
// random idling on both sides. A predictor built into the bench tracks the
// look-ahead window and computes every output code point with its run_last
// and name_done flags. Each output beat is checked against the oldest
// expected one. The colon setting is changed between phases while the block
// is idle.
// ============================================================================
module xml_ncname_ucs2_escaper_test;
   import xnce_pkg::*;

   localparam int CYCLE_LIMIT  = 5000000;
   localparam int SETTLE_PAD   = 10;
   localparam int PHASE_ITEMS  = 68;
   localparam int NUM_PHASES   = 4;
   localparam int MAX_REPORTS  = 10;

   localparam logic [CODE_W-1:0] DIGIT_0  = 21'h30;
   localparam logic [CODE_W-1:0] LETTER_A = 21'h41;

   // Ranges of characters that may start a name (colon is handled apart).
   localparam int NUM_START = 15;
   localparam logic [CODE_W-1:0] START_LO [0:NUM_START-1] = '{
      21'h41, 21'h5F, 21'h61, 21'hC0, 21'hD8, 21'hF8, 21'h370, 21'h37F,
      21'h200C, 21'h2070, 21'h2C00, 21'h3001, 21'hF900, 21'hFDF0, 21'h10000};
   localparam logic [CODE_W-1:0] START_HI [0:NUM_START-1] = '{
      21'h5A, 21'h5F, 21'h7A, 21'hD6, 21'hF6, 21'h2FF, 21'h37D, 21'h1FFF,
      21'h200D, 21'h218F, 21'h2FEF, 21'hD7FF, 21'hFDCF, 21'hFFFD, 21'hEFFFF};

   // Further ranges that are allowed only after the first character.
   localparam int NUM_EXTRA = 5;
   localparam logic [CODE_W-1:0] EXTRA_LO [0:NUM_EXTRA-1] = '{
      21'h2D, 21'h30, 21'hB7, 21'h300, 21'h203F};
   localparam logic [CODE_W-1:0] EXTRA_HI [0:NUM_EXTRA-1] = '{
      21'h2E, 21'h39, 21'hB7, 21'h36F, 21'h2040};

   // Codes on and next to the borders of the character classes.
   localparam int NUM_BOUNDARY = 63;
   localparam logic [CODE_W-1:0] BOUNDARY [0:NUM_BOUNDARY-1] = '{
      21'h2F, 21'h30, 21'h39, 21'h3A, 21'h40, 21'h41, 21'h5A, 21'h5B,
      21'h60, 21'h61, 21'h7A, 21'h7B, 21'hBF, 21'hC0, 21'hD6, 21'hD7,
      21'hD8, 21'hF6, 21'hF7, 21'hF8, 21'h2FF, 21'h300, 21'h36F, 21'h370,
      21'h37D, 21'h37E, 21'h37F, 21'h1FFF, 21'h2000, 21'h200C, 21'h200D,
      21'h200E, 21'h203E, 21'h203F, 21'h2040, 21'h2041, 21'h206F, 21'h2070,
      21'h218F, 21'h2190, 21'h2BFF, 21'h2C00, 21'h2FEF, 21'h2FF0, 21'h3000,
      21'h3001, 21'hD7FF, 21'hD800, 21'hF8FF, 21'hF900, 21'hFDCF, 21'hFDD0,
      21'hFDEF, 21'hFDF0, 21'hFFFD, 21'hFFFE, 21'hFFFF, 21'h10000, 21'hEFFFF,
      21'hF0000, 21'h10FFFF, 21'h110000, 21'h1FFFFF};

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Stimulus and expectation stores.
   req_type pending_chars[$];
   rsp_type expected_codes[$];
   rsp_type beat_codes[$];

   // Predictor state.
   logic [CODE_W-1:0] lookahead [0:6];
   int                lookahead_n    = 0;
   bit                at_name_start  = 1'b1;
   bit                colon_escaped  = 1'b0;

   // Bookkeeping.
   int issued_n     = 0;
   int accepted_n   = 0;
   int phase_items  = 0;
   int names_n      = 0;
   int escapes_n    = 0;
   int checked_n    = 0;
   int mismatches   = 0;
   int csr_writes   = 0;
   int cycles       = 0;
   int send_gap     = 0;
   int send_calm    = 0;
   int recv_stall   = 0;
   int recv_calm    = 0;

   xml_ncname_ucs2_escaper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock: 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Character classes
   // ------------------------------------------------------------------------
   function automatic bit may_start(input logic [CODE_W-1:0] c);
      bit hit;
      hit = (c == CH_COLON) && !colon_escaped;
      for (int i = 0; i < NUM_START; i++)
         if (c >= START_LO[i] && c <= START_HI[i]) hit = 1'b1;
      return hit;
   endfunction

   function automatic bit is_name_char(input logic [CODE_W-1:0] c);
      bit hit;
      hit = may_start(c);
      for (int i = 0; i < NUM_EXTRA; i++)
         if (c >= EXTRA_LO[i] && c <= EXTRA_HI[i]) hit = 1'b1;
      return hit;
   endfunction

   function automatic bit is_word_char(input logic [CODE_W-1:0] c);
      return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h5A)
          || (c >= 21'h61 && c <= 21'h7A);
   endfunction

   function automatic logic [CODE_W-1:0] hex_digit(input logic [3:0] n);
      return (n < 4'd10) ? DIGIT_0 + CODE_W'(n) : LETTER_A + CODE_W'(n - 4'd10);
   endfunction

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void put_plain(input logic [CODE_W-1:0] c);
      rsp_type t;
      t.out_code  = c;
      t.run_last  = 1'b0;
      t.name_done = 1'b0;
      beat_codes.push_back(t);
   endfunction

   // A non-name character becomes _xHHHH_ from its low 16 bits.
   function automatic void put_escape(input logic [CODE_W-1:0] c);
      put_plain(CH_UNDERSCORE);
      put_plain(CH_X);
      put_plain(hex_digit(c[15:12]));
      put_plain(hex_digit(c[11:8]));
      put_plain(hex_digit(c[7:4]));
      put_plain(hex_digit(c[3:0]));
      put_plain(CH_UNDERSCORE);
      escapes_n++;
   endfunction

   function automatic bit pattern_at_head();
      return lookahead[0] == CH_UNDERSCORE && lookahead[1] == CH_X
          && is_word_char(lookahead[2]) && is_word_char(lookahead[3])
          && is_word_char(lookahead[4]) && is_word_char(lookahead[5])
          && lookahead[6] == CH_UNDERSCORE;
   endfunction

   // Works out every output beat caused by one accepted input beat.
   function automatic void encode_beat(input req_type beat);
      logic [CODE_W-1:0] head;
      rsp_type           tail;
      int                i;
      beat_codes.delete();
      if (at_name_start) begin
         if (may_start(beat.char_code))
            put_plain(beat.char_code);
         else
            put_escape(beat.char_code);
         at_name_start = 1'b0;
         lookahead_n   = 0;
      end else begin
         lookahead[lookahead_n] = beat.char_code;
         lookahead_n++;
         // A full window decides its head and slides by one.
         if (lookahead_n == 7) begin
            head = lookahead[0];
            if (!pattern_at_head() && is_name_char(head))
               put_plain(head);
            else
               put_escape(head);
            for (i = 0; i < 6; i++)
               lookahead[i] = lookahead[i + 1];
            lookahead_n = 6;
         end
      end
      // At the end of a name every held character is tested on its own.
      if (beat.name_end) begin
         for (i = 0; i < lookahead_n; i++) begin
            if (is_name_char(lookahead[i]))
               put_plain(lookahead[i]);
            else
               put_escape(lookahead[i]);
         end
         lookahead_n   = 0;
         at_name_start = 1'b1;
         names_n++;
      end
      if (beat_codes.size() > 0) begin
         tail           = beat_codes.pop_back();
         tail.run_last  = 1'b1;
         tail.name_done = beat.name_end;
         beat_codes.push_back(tail);
      end
      for (i = 0; i < beat_codes.size(); i++)
         expected_codes.push_back(beat_codes[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_char(input logic [CODE_W-1:0] c, input bit last);
      req_type r;
      r.char_code = c;
      r.name_end  = last;
      pending_chars.push_back(r);
      phase_items++;
   endfunction

   function automatic logic [CODE_W-1:0] pick_word_char();
      case ($urandom_range(0, 2))
         0:       return CODE_W'($urandom_range(21'h41, 21'h5A));
         1:       return CODE_W'($urandom_range(21'h61, 21'h7A));
         default: return CODE_W'($urandom_range(21'h30, 21'h39));
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] pick_char();
      case ($urandom_range(0, 11))
         0, 1, 2: return pick_word_char();
         3:       return $urandom_range(0, 1) ? CH_UNDERSCORE : CH_X;
         4: begin
            case ($urandom_range(0, 3))
               0:       return CH_HYPHEN;
               1:       return CH_PERIOD;
               2:       return CH_COLON;
               default: return CH_MIDDOT;
            endcase
         end
         5, 6:    return BOUNDARY[$urandom_range(0, NUM_BOUNDARY - 1)];
         7:       return CODE_W'($urandom_range(21'h80, 21'hFFFF));
         8:       return CODE_W'($urandom_range(0, 21'h1FFFFF));
         9:       return CODE_W'($urandom_range(0, 21'h7F));
         10:      return CODE_W'($urandom_range(21'h10000, 21'h10FFFF));
         default: return CODE_W'($urandom_range(21'h300, 21'h36F));
      endcase
   endfunction

   // One random name, often holding underscore patterns, some of them spoilt.
   task automatic queue_name();
      logic [CODE_W-1:0] chars[$];
      int                len;
      int                spoil;
      int                k;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      chars.push_back(pick_char());
      while (chars.size() < len) begin
         if ($urandom_range(0, 3) == 0) begin
            chars.push_back(CH_UNDERSCORE);
            chars.push_back(CH_X);
            repeat (4) chars.push_back(pick_word_char());
            chars.push_back(CH_UNDERSCORE);
            if ($urandom_range(0, 2) == 0) begin
               spoil = $urandom_range(1, 7);
               if (spoil == 7)
                  void'(chars.pop_back());
               else
                  chars[chars.size() - 7 + spoil] = pick_char();
            end
         end else begin
            chars.push_back(pick_char());
         end
      end
      for (k = 0; k < chars.size(); k++)
         add_char(chars[k], k == chars.size() - 1);
   endtask

   // Mostly no gap, often a short one, now and then a long one, with calm
   // stretches in which there is no idling at all.
   function automatic int draw_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // Holds the sender back until every expected output beat has arrived.
   task automatic wait_until_idle();
      while (pending_chars.size() != 0 || accepted_n != issued_n
             || expected_codes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   task automatic write_colon_setting(input bit value);
      @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Input driver: changes at the falling edge, one beat at a time.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || accepted_n == issued_n)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_chars.size() > 0) begin
            req_data  <= pending_chars.pop_front();
            req_valid <= 1'b1;
            issued_n++;
            send_gap = draw_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output side back-pressure.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_stall > 0) begin
            rsp_ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_ready  <= 1'b1;
            recv_stall = ($urandom_range(0, 2) == 0) ? draw_gap(recv_calm) : 0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predicts on accepted input beats and checks output beats.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input rsp_type want,
                                  input rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s: expected code %h last %b done %b, got code %h last %b done %b",
                  what, want.out_code, want.run_last, want.name_done,
                  got.out_code, got.run_last, got.name_done);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycles);
         $display("[xml_ncname_ucs2_escaper] ERROR");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            encode_beat(req_data);
            accepted_n++;
         end
         if (rsp_valid && rsp_ready) begin
            checked_n++;
            if (expected_codes.size() == 0) begin
               want = '0;
               report_mismatch("Unexpected output beat", want, rsp_data);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_data.out_code !== want.out_code
                   || rsp_data.run_last !== want.run_last
                   || rsp_data.name_done !== want.name_done)
                  report_mismatch("Output mismatch", want, rsp_data);
            end
         end
         if (csr_wr_en)
            colon_escaped = csr_wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, then phases with alternating colon settings.
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            wait_until_idle();
            write_colon_setting(1'(phase % 2));
         end
         phase_items = 0;
         if (phase == 0) begin
            // Single-character names: above the code range, zero, colon.
            add_char(21'h1FFFFF, 1'b1);
            add_char(21'h000000, 1'b1);
            add_char(CH_COLON, 1'b1);
            // Supplementary non-name character whose low 16 bits are zero.
            add_char(21'hF0000, 1'b1);
            // Name characters that may not start a name.
            add_char(CH_HYPHEN, 1'b0);
            add_char(CH_PERIOD, 1'b0);
            add_char(CH_MIDDOT, 1'b1);
            // "a_x12Zz_b": the inner underscore starts the pattern.
            add_char(21'h61, 1'b0);
            add_char(CH_UNDERSCORE, 1'b0);
            add_char(CH_X, 1'b0);
            add_char(21'h31, 1'b0);
            add_char(21'h32, 1'b0);
            add_char(21'h5A, 1'b0);
            add_char(21'h7A, 1'b0);
            add_char(CH_UNDERSCORE, 1'b0);
            add_char(21'h62, 1'b1);
            // Flush of held name and non-name characters at the end of a name.
            add_char(21'h71, 1'b0);
            add_char(21'h10FFFF, 1'b0);
            add_char(21'h300, 1'b0);
            add_char(21'h2041, 1'b0);
            add_char(CH_UNDERSCORE, 1'b1);
         end else if (phase == 1) begin
            // Colon escaped, both as first and as later character.
            add_char(CH_COLON, 1'b1);
            add_char(21'h61, 1'b0);
            add_char(CH_COLON, 1'b1);
         end
         while (phase_items < PHASE_ITEMS)
            queue_name();
      end

      wait_until_idle();
      repeat (2 * SETTLE_PAD) @(posedge clock);

      if (expected_codes.size() != 0) begin
         mismatches += expected_codes.size();
         $display("%0d expected output beats never arrived", expected_codes.size());
      end
      $display("Sent %0d characters in %0d names under %0d colon setting changes;",
               accepted_n, names_n, csr_writes);
      $display("checked %0d output beats holding %0d escape sequences, %0d mismatches.",
               checked_n, escapes_n, mismatches);
      if (mismatches == 0) begin
         $display("[xml_ncname_ucs2_escaper] OK");
      end else begin
         $display("[xml_ncname_ucs2_escaper] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/xnce_pkg.sv
rtl/xnce_window.sv
rtl/xnce_expand.sv
rtl/xml_ncname_ucs2_escaper.sv
test/xml_ncname_ucs2_escaper_test.sv
